[rtl/core/matrix_top_k_selector_assert.svh]
// assertion macros used by the top-k selector chain
`ifndef MATRIX_TOP_K_SELECTOR_ASSERT_SVH
`define MATRIX_TOP_K_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TKS_ASSERT_IMP(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("top-k selector: implication failed");

// next-cycle implication, disabled while in reset
`define TKS_ASSERT_NXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("top-k selector: next-cycle check failed");

`endif

[rtl/core/tks_pkg.sv]
// types and constants shared by the top-k selector modules
package tks_pkg;

    localparam int VAL_W = 16;
    localparam int IDX_W = 7;
    localparam int CNT_W = 6;
    localparam int LIM_W = 7;

    localparam logic [CNT_W-1:0] TOP_COUNT_RST = 6'd50;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic shift;
        logic clr;
    } chain_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

endpackage

[rtl/core/tks_cell.sv]
// one rank slot: compare against the incoming entry, insert, shift or clear
module tks_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  tks_pkg::chain_ctrl_t ctrl,
    input  tks_pkg::entry_t     new_entry,
    input  tks_pkg::entry_t     prev_entry,
    input  logic                prev_valid,
    input  logic                prev_wins,
    input  tks_pkg::entry_t     next_entry,
    input  logic                next_valid,
    output tks_pkg::entry_t     entry,
    output logic                valid,
    output logic                wins
);
    import tks_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // new entry ranks above this slot on equal value
    assign wins = !valid_reg || (entry_reg.value <= new_entry.value);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins)
        begin
            if (wins && !prev_wins)
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
            else if (prev_wins)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
        end
        else if (ctrl.shift)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/tks_chain.sv]
// row of rank cells, slot 0 holds the largest kept entry
`include "matrix_top_k_selector_assert.svh"

module tks_chain
#(
    parameter int TOP_K = 50
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tks_pkg::chain_ctrl_t ctrl,
    input  tks_pkg::entry_t      new_entry,
    output tks_pkg::entry_t      head_entry,
    output logic                 head_valid,
    output logic                 second_valid
);
    import tks_pkg::*;

    entry_t           cell_entry [TOP_K];
    logic [TOP_K-1:0] valid_vec;
    logic [TOP_K-1:0] wins_vec;

    genvar i;
    generate
        for (i = 0; i < TOP_K; i++)
        begin : g_cell
            entry_t prev_e;
            logic   prev_v;
            logic   prev_w;
            entry_t next_e;
            logic   next_v;

            if (i == 0)
            begin : g_first
                assign prev_e = new_entry;
                assign prev_v = 1'b0;
                assign prev_w = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = cell_entry[i-1];
                assign prev_v = valid_vec[i-1];
                assign prev_w = wins_vec[i-1];
            end

            if (i == TOP_K - 1)
            begin : g_tail
                assign next_e = new_entry;
                assign next_v = 1'b0;
            end
            else
            begin : g_body
                assign next_e = cell_entry[i+1];
                assign next_v = valid_vec[i+1];
            end

            tks_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_valid (prev_v),
                .prev_wins  (prev_w),
                .next_entry (next_e),
                .next_valid (next_v),
                .entry      (cell_entry[i]),
                .valid      (valid_vec[i]),
                .wins       (wins_vec[i])
            );
        end

        if (TOP_K > 1)
        begin : g_second
            assign second_valid = valid_vec[1];
        end
        else
        begin : g_single
            assign second_valid = 1'b0;
        end
    endgenerate

    assign head_entry = cell_entry[0];
    assign head_valid = valid_vec[0];

    // occupied slots always form a prefix starting at rank 0
    `TKS_ASSERT_IMP(a_valid_prefix, clk, rst_n, 1'b1, (valid_vec & (valid_vec + TOP_K'(1))) == '0)
    `TKS_ASSERT_NXT(a_clear_empties, clk, rst_n, ctrl.clr, valid_vec == '0)
    `TKS_ASSERT_IMP(a_ins_no_shift, clk, rst_n, ctrl.ins, !ctrl.shift && !ctrl.clr)

endmodule

[rtl/core/tks_ctrl.sv]
// insert/drain sequencer and result output register
module tks_ctrl
#(
    parameter int TOP_K = 50
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      last_entry,
    input  logic [tks_pkg::CNT_W-1:0] top_count,
    input  tks_pkg::entry_t           head_entry,
    input  logic                      head_valid,
    input  logic                      second_valid,
    output tks_pkg::chain_ctrl_t      ctrl,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [tks_pkg::CNT_W-1:0] rank,
    output tks_pkg::entry_t           out_entry,
    output logic                      last_result
);
    import tks_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [LIM_W-1:0]  count_reg;
    logic [LIM_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    entry_t            out_entry_reg;
    logic [CNT_W-1:0]  rank_reg;
    logic              last_reg;

    logic [LIM_W-1:0]  limit;
    logic              accept;
    logic              can_load;
    logic              emit;
    logic              final_one;
    logic              drain_done;

    assign limit = ({1'b0, top_count} > LIM_W'(TOP_K)) ? LIM_W'(TOP_K) : {1'b0, top_count};
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign can_load   = !out_valid_reg || !out_stall;
    assign emit       = (state_reg == ST_DRAIN) && can_load && head_valid && (count_reg < limit);
    assign final_one  = (LIM_W'(count_reg + 1'b1) >= limit) || !second_valid;
    // zero count or nothing left to send
    assign drain_done = (state_reg == ST_DRAIN) && (!head_valid || (count_reg >= limit));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_entry)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done || (emit && final_one))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl       = '0;
        in_stall   = 1'b1;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                ctrl.ins   = accept;
                count_next = '0;
            end
            ST_DRAIN:
            begin
                ctrl.shift = emit;
                ctrl.clr   = drain_done || (emit && final_one);
                if (emit)
                begin
                    count_next = LIM_W'(count_reg + 1'b1);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_entry_reg <= head_entry;
            rank_reg      <= count_reg[CNT_W-1:0];
            last_reg      <= final_one;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_entry   = out_entry_reg;
    assign rank        = rank_reg;
    assign last_result = last_reg;

endmodule

[rtl/core/matrix_top_k_selector.sv]
// top-k selector: keeps the largest map entries and emits them ranked
//
// input channel (in_valid / in_stall): one map entry per transaction with its
//   value, row and column; last_entry marks the final entry of a map.
// entries are taken one per cycle while idle; each is placed into a row of TOP_K rank
//   cells in the same cycle it is accepted (later arrivals win ties).
// after the last entry the block stalls its input and drains the ranked list
//   from rank 0, one result per cycle while the output is not stalled,
//   min(top_count, TOP_K) results or fewer if fewer entries are held; the
//   first result is loaded into the output register in the drain state after
//   the last entry, and the cell row shifts up one slot per emitted result.
// output channel (out_valid / out_stall): one ranked result per transaction,
//   last_result set on the final one. a stall holds the output register and
//   freezes the drain; input stays stalled until the drain completes and the
//   list is cleared for the next map.
// cfg_we / cfg_wdata write top_count; write only while the block is idle.
// reset empties the list, clears out_valid and sets top_count to 50.
module matrix_top_k_selector
#(
    parameter int TOP_K = 50
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tks_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [tks_pkg::VAL_W-1:0] entry_value,
    input  logic [tks_pkg::IDX_W-1:0] row_index,
    input  logic [tks_pkg::IDX_W-1:0] col_index,
    input  logic                      last_entry,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [tks_pkg::CNT_W-1:0] rank,
    output logic [tks_pkg::VAL_W-1:0] out_value,
    output logic [tks_pkg::IDX_W-1:0] out_row,
    output logic [tks_pkg::IDX_W-1:0] out_col,
    output logic                      last_result
);
    import tks_pkg::*;

    logic [CNT_W-1:0] top_count_reg;
    logic [CNT_W-1:0] top_count_next;
    entry_t           new_entry;
    entry_t           head_entry;
    entry_t           out_entry;
    logic             head_valid;
    logic             second_valid;
    chain_ctrl_t      ctrl;

    assign top_count_next = cfg_we ? cfg_wdata : top_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= TOP_COUNT_RST;
        end
        else
        begin
            top_count_reg <= top_count_next;
        end
    end

    assign new_entry.value = entry_value;
    assign new_entry.row   = row_index;
    assign new_entry.col   = col_index;

    tks_chain #(.TOP_K(TOP_K)) u_chain
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_entry    (new_entry),
        .head_entry   (head_entry),
        .head_valid   (head_valid),
        .second_valid (second_valid)
    );

    tks_ctrl #(.TOP_K(TOP_K)) u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .last_entry   (last_entry),
        .top_count    (top_count_reg),
        .head_entry   (head_entry),
        .head_valid   (head_valid),
        .second_valid (second_valid),
        .ctrl         (ctrl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rank         (rank),
        .out_entry    (out_entry),
        .last_result  (last_result)
    );

    assign out_value = out_entry.value;
    assign out_row   = out_entry.row;
    assign out_col   = out_entry.col;

endmodule
